/* hdl/ivta_pkg.sv */
// shared types, codes and field widths for the interrupt vector table allocator
// no dependencies; used by ivta_ctrl, ivta_datapath and the top level
`default_nettype none

package ivta_pkg;

  localparam int MAX_ADAPTERS_DEF        = 8;
  localparam int VECTORS_PER_ADAPTER_DEF = 256;

  localparam int FUNC_W      = 3;
  localparam int ADAPTER_W   = 3;
  localparam int VEC_W       = 8;
  localparam int HANDLER_W   = 16;
  localparam int ARG_W       = 32;
  localparam int STATUS_W    = 3;
  localparam int CFG_W       = 4;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 64;
  localparam int OUT_FIELD_W = STATUS_W + VEC_W + HANDLER_W + ARG_W + 1;

  localparam logic [VEC_W-1:0] SKIP_VECTOR_HIGH = 8'd255;

  typedef enum logic [FUNC_W-1:0] {
    FN_BIND     = 3'd0,
    FN_ALLOC    = 3'd1,
    FN_FREE     = 3'd2,
    FN_DISPATCH = 3'd3,
    FN_NO_FLUSH = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_INVALID    = 3'd1,
    ST_BOUND      = 3'd2,
    ST_NONE_FREE  = 3'd3,
    ST_STRAY      = 3'd4,
    ST_NO_HANDLER = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    KIND_FREE     = 2'd0,
    KIND_RESERVED = 2'd1,
    KIND_BOUND    = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [HANDLER_W-1:0]  handler;
    logic signed [ARG_W-1:0] arg;
    logic                  flush;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic idle;
    logic accept;
    logic clear;
    logic scan;
    logic exec;
    logic alloc_done;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic alloc_go;
    logic found;
    logic exhausted;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* hdl/ivta_ctrl.sv */
// controller state machine: clearing pass, accept, execute, allocation scan
// depends on ivta_pkg
`default_nettype none

module ivta_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire ivta_pkg::sts_t sts,
  output ivta_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_ALLOC_DONE
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    s_tready   = 1'b0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.idle = 1'b1;
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = sts.alloc_go ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found || sts.exhausted) state_next = S_ALLOC_DONE;
      end
      S_ALLOC_DONE: begin
        if (sts.out_free) begin
          cmd.alloc_done = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/ivta_datapath.sv */
// datapath: vector table memory, search pointers, scan counters, result register
// depends on ivta_pkg; driven by ivta_ctrl
`default_nettype none

module ivta_datapath #(
  parameter int MAX_ADAPTERS        = ivta_pkg::MAX_ADAPTERS_DEF,
  parameter int VECTORS_PER_ADAPTER = ivta_pkg::VECTORS_PER_ADAPTER_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [ivta_pkg::CFG_W-1:0]        cfg_wr_data,
  input  wire logic [ivta_pkg::FUNC_W-1:0]       s_tuser,
  input  wire logic [ivta_pkg::IN_DATA_W-1:0]    s_tdata,
  input  wire logic                              m_tready,
  output logic                                   m_tvalid,
  output logic [ivta_pkg::OUT_DATA_W-1:0]        m_tdata,
  input  wire ivta_pkg::cmd_t                    cmd,
  output ivta_pkg::sts_t                         sts
);

  localparam int DEPTH = MAX_ADAPTERS * VECTORS_PER_ADAPTER;
  localparam int AW    = $clog2(DEPTH);
  localparam int AIW   = (MAX_ADAPTERS > 1) ? $clog2(MAX_ADAPTERS) : 1;
  localparam int CW    = $clog2(VECTORS_PER_ADAPTER + 1);
  localparam int VW    = ivta_pkg::VEC_W;
  localparam int HW    = ivta_pkg::HANDLER_W;
  localparam int ARW   = ivta_pkg::ARG_W;
  localparam int PAD_W = ivta_pkg::OUT_DATA_W - ivta_pkg::OUT_FIELD_W;

  localparam logic [VW-1:0] VEC_LAST  = VW'(VECTORS_PER_ADAPTER - 1);
  localparam logic [CW-1:0] CNT_LAST  = CW'(VECTORS_PER_ADAPTER - 1);
  localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

  function automatic logic [VW-1:0] vec_inc(input logic [VW-1:0] v);
    return (v == VEC_LAST) ? '0 : VW'(v + 1'b1);
  endfunction

  // input beat fields
  ivta_pkg::func_t             in_func;
  logic [ivta_pkg::ADAPTER_W-1:0] in_adapter;
  logic [3:0]                  in_adapter_x;
  logic [VW-1:0]               in_vec;
  logic [HW-1:0]               in_handler;
  logic signed [ARW-1:0]       in_arg;
  logic                        in_aok, in_vok;
  logic [AIW-1:0]              in_aidx;
  logic [AW-1:0]               in_base, in_slot;

  logic [ivta_pkg::CFG_W-1:0]  adapters_present;
  logic [VW-1:0]               ptr [MAX_ADAPTERS];

  // registered operation
  ivta_pkg::func_t             r_func;
  logic [VW-1:0]               r_vec;
  logic [HW-1:0]               r_handler;
  logic signed [ARW-1:0]       r_arg;
  logic                        r_aok, r_vok;
  logic [AIW-1:0]              r_aidx;
  logic [AW-1:0]               r_base, r_slot;

  // scan state
  logic [VW-1:0]               scan_v, chk_v;
  logic [CW-1:0]               scan_cnt, chk_cnt;
  logic                        chk_valid, alloc_hit, scan_stop;

  // clearing pass
  logic [AW-1:0]               clr_addr;
  logic [VW-1:0]               clr_v;

  // table memory
  ivta_pkg::entry_t            mem [DEPTH];
  ivta_pkg::entry_t            rd_data, wr_data;
  logic [AW-1:0]               rd_addr, wr_addr;
  logic                        wr_en;

  // result
  ivta_pkg::status_t           res_status, out_status;
  logic [VW-1:0]               res_vec, out_vec;
  logic [HW-1:0]               res_handler, out_handler;
  logic signed [ARW-1:0]       res_arg, out_arg;
  logic                        res_flush, out_flush, out_valid;

  assign in_func      = ivta_pkg::func_t'(s_tuser);
  assign in_adapter   = s_tdata[2:0];
  assign in_vec       = s_tdata[10:3];
  assign in_handler   = s_tdata[26:11];
  assign in_arg       = s_tdata[58:27];
  assign in_adapter_x = {1'b0, in_adapter};
  assign in_aidx      = in_adapter_x[AIW-1:0];

  assign in_aok = ({1'b0, in_adapter} < adapters_present) &&
                  (5'(in_adapter) < 5'(MAX_ADAPTERS));
  assign in_vok = ({1'b0, in_vec} < 9'(VECTORS_PER_ADAPTER));

  assign in_base = in_aok ? AW'(32'(in_adapter) * VECTORS_PER_ADAPTER) : '0;
  assign in_slot = (in_aok && in_vok) ? AW'(in_base + AW'(in_vec)) : '0;

  // the entry checked this cycle is the one addressed in the previous cycle
  assign sts.found = chk_valid && (chk_v != '0) && (chk_v != ivta_pkg::SKIP_VECTOR_HIGH) &&
                     (rd_data.kind == ivta_pkg::KIND_FREE);
  assign sts.exhausted = chk_valid && !sts.found && (chk_cnt == CNT_LAST);
  assign sts.alloc_go  = (in_func == ivta_pkg::FN_ALLOC) && in_aok;
  assign sts.clr_last  = (clr_addr == ADDR_LAST);
  assign sts.out_free  = !out_valid || m_tready;
  assign scan_stop     = sts.found || sts.exhausted;

  always_comb begin
    if (cmd.scan) begin
      rd_addr = AW'(r_base + AW'(scan_v));
    end else if (cmd.idle) begin
      rd_addr = in_slot;
    end else begin
      rd_addr = r_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      r_func    <= in_func;
      r_vec     <= in_vec;
      r_handler <= in_handler;
      r_arg     <= in_arg;
      r_aok     <= in_aok;
      r_vok     <= in_vok;
      r_aidx    <= in_aidx;
      r_base    <= in_base;
      r_slot    <= in_slot;
      scan_v    <= in_aok ? ptr[in_aidx] : '0;
      scan_cnt  <= '0;
    end else if (cmd.scan && !scan_stop) begin
      chk_v    <= scan_v;
      chk_cnt  <= scan_cnt;
      scan_v   <= vec_inc(scan_v);
      scan_cnt <= CW'(scan_cnt + 1'b1);
    end
    if (cmd.exec || cmd.alloc_done) begin
      out_status  <= res_status;
      out_vec     <= res_vec;
      out_handler <= res_handler;
      out_arg     <= res_arg;
      out_flush   <= res_flush;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      adapters_present <= ivta_pkg::CFG_W'(1);
      for (int i = 0; i < MAX_ADAPTERS; i++) ptr[i] <= '0;
      chk_valid <= 1'b0;
      alloc_hit <= 1'b0;
      clr_addr  <= '0;
      clr_v     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) adapters_present <= cfg_wr_data;
      if (cmd.clear) begin
        clr_addr <= AW'(clr_addr + 1'b1);
        clr_v    <= vec_inc(clr_v);
      end
      if (cmd.accept) begin
        chk_valid <= 1'b0;
        alloc_hit <= 1'b0;
      end else if (cmd.scan) begin
        if (!scan_stop) chk_valid <= 1'b1;
        if (sts.found) alloc_hit <= 1'b1;
      end
      if (cmd.alloc_done && alloc_hit) ptr[r_aidx] <= vec_inc(chk_v);
      if (cmd.exec || cmd.alloc_done) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = r_slot;
    wr_data     = rd_data;
    res_status  = ivta_pkg::ST_INVALID;
    res_vec     = r_vec;
    res_handler = '0;
    res_arg     = '0;
    res_flush   = 1'b0;
    if (cmd.clear) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '{kind: ivta_pkg::KIND_FREE, handler: '0, arg: ARW'(clr_v), flush: 1'b0};
    end else if (cmd.alloc_done) begin
      res_vec = '0;
      if (alloc_hit) begin
        wr_en      = 1'b1;
        wr_addr    = AW'(r_base + AW'(chk_v));
        wr_data    = '{kind: ivta_pkg::KIND_RESERVED, handler: '0, arg: ARW'(chk_v),
                       flush: 1'b1};
        res_status = ivta_pkg::ST_OK;
        res_vec    = chk_v;
        res_flush  = 1'b1;
      end else begin
        res_status = ivta_pkg::ST_NONE_FREE;
      end
    end else if (cmd.exec) begin
      unique case (r_func)
        ivta_pkg::FN_BIND: begin
          if (r_aok && r_vok && (r_handler != '0)) begin
            if (rd_data.kind == ivta_pkg::KIND_BOUND) begin
              res_status = ivta_pkg::ST_BOUND;
              res_flush  = rd_data.flush;
            end else begin
              wr_en      = 1'b1;
              wr_data    = '{kind: ivta_pkg::KIND_BOUND, handler: r_handler, arg: r_arg,
                             flush: 1'b1};
              res_status = ivta_pkg::ST_OK;
              res_flush  = 1'b1;
            end
          end
        end
        // only an invalid adapter gets here; valid ones go through the scan
        ivta_pkg::FN_ALLOC: res_vec = '0;
        ivta_pkg::FN_FREE: begin
          if (r_aok && r_vok) begin
            wr_en      = 1'b1;
            wr_data    = '{kind: ivta_pkg::KIND_FREE, handler: '0, arg: ARW'(r_vec),
                           flush: 1'b0};
            res_status = ivta_pkg::ST_OK;
          end
        end
        ivta_pkg::FN_DISPATCH: begin
          if (r_aok) begin
            if (!r_vok) begin
              res_status = ivta_pkg::ST_STRAY;
            end else begin
              res_arg   = rd_data.arg;
              res_flush = rd_data.flush;
              unique case (rd_data.kind)
                ivta_pkg::KIND_BOUND: begin
                  res_status  = ivta_pkg::ST_OK;
                  res_handler = rd_data.handler;
                end
                ivta_pkg::KIND_RESERVED: res_status = ivta_pkg::ST_NO_HANDLER;
                default:                 res_status = ivta_pkg::ST_STRAY;
              endcase
            end
          end
        end
        ivta_pkg::FN_NO_FLUSH: begin
          if (r_aok && r_vok) begin
            if (rd_data.kind == ivta_pkg::KIND_BOUND) begin
              wr_en         = 1'b1;
              wr_data.flush = 1'b0;
              res_status    = ivta_pkg::ST_OK;
            end else begin
              res_flush = rd_data.flush;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{PAD_W{1'b0}}, out_flush, out_arg, out_handler, out_vec, out_status};

endmodule

`default_nettype wire

/* hdl/interrupt_vector_table_allocator.sv */
// top level of the interrupt vector table allocator
// depends on ivta_pkg, ivta_ctrl and ivta_datapath
//
//   channel   handshake             payload
//   input     s_tvalid / s_tready   s_tuser func, s_tdata adapter/vector/handler/arg
//   result    m_tvalid / m_tready   m_tdata status/vector/handler/arg/flush
//   config    cfg_wr_en             cfg_wr_data adapters_present
//
// bind, free, dispatch, disable flush, unused codes and allocate on an invalid adapter
// go through one table read, then one read-modify-write into the result register
// allocate on a valid adapter scans from the search pointer, one table read per cycle,
// and examines at most VECTORS_PER_ADAPTER entries
// after reset a clearing pass writes all MAX_ADAPTERS * VECTORS_PER_ADAPTER entries
// (2048 by default) of the table; no beat is accepted meanwhile
// a result waits in the output register while m_tready is low
`default_nettype none

module interrupt_vector_table_allocator #(
  parameter int MAX_ADAPTERS        = ivta_pkg::MAX_ADAPTERS_DEF,
  parameter int VECTORS_PER_ADAPTER = ivta_pkg::VECTORS_PER_ADAPTER_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration: adapters_present
  input  wire logic                           cfg_wr_en,
  input  wire logic [ivta_pkg::CFG_W-1:0]     cfg_wr_data,
  // input beats
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // func[2:0]
  input  wire logic [ivta_pkg::FUNC_W-1:0]    s_tuser,
  // adapter_index[2:0], vector_number[10:3], handler_id[26:11], handler_arg[58:27]
  input  wire logic [ivta_pkg::IN_DATA_W-1:0] s_tdata,
  // result beats
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // status[2:0], vector_out[10:3], handler_out[26:11], arg_out[58:27],
  // flush_enabled[59]
  output logic [ivta_pkg::OUT_DATA_W-1:0]     m_tdata
);

  ivta_pkg::cmd_t cmd;
  ivta_pkg::sts_t sts;

  ivta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ivta_datapath #(
    .MAX_ADAPTERS        (MAX_ADAPTERS),
    .VECTORS_PER_ADAPTER (VECTORS_PER_ADAPTER)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tuser     (s_tuser),
    .s_tdata     (s_tdata),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .m_tdata     (m_tdata),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

`default_nettype wire
